// ===== sv/assert_macros.svh =====
// Assertion macros shared by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_NOW(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== sv/ple_pkg.sv =====
// Types, codes and constants of the positional list engine.
package ple_pkg;

    localparam int DEF_CAPACITY = 128;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int GRP_SIZE     = 16;
    localparam int GRP_IW       = $clog2(GRP_SIZE);

    localparam logic [2:0] FN_INSERT  = 3'd0;
    localparam logic [2:0] FN_DELETE  = 3'd1;
    localparam logic [2:0] FN_LOCATE  = 3'd2;
    localparam logic [2:0] FN_REVERSE = 3'd3;
    localparam logic [2:0] FN_CLEAR   = 3'd4;
    localparam logic [2:0] FN_READ    = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [2:0]               func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [POS_W-1:0]         found_position;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         count;
    } rsp_t;

    typedef struct packed {
        logic ins;
        logic del;
    } cell_cmd_t;

    typedef struct packed {
        logic              hit;
        logic [GRP_IW-1:0] first;
        logic [GRP_IW-1:0] last;
        logic [DATA_W-1:0] data;
    } grp_res_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_REDUCE,
        FSM_COMBINE
    } fsm_t;

endpackage

// ===== sv/ple_cell.sv =====
// One storage cell of the list: holds an entry, shifts toward either neighbor.
module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 7
)
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [IW-1:0]     phys,
    input  logic [DATA_W-1:0] value,
    input  logic [DATA_W-1:0] left,
    input  logic [DATA_W-1:0] right,
    output logic [DATA_W-1:0] q,
    output logic              match
);

    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] q_next;
    logic [IW-1:0]     my_idx;

    assign my_idx = IW'(IDX);

    always_comb
    begin
        q_next = q_reg;
        if (cmd.ins && my_idx == phys)
        begin
            q_next = value;
        end
        else if (cmd.ins && my_idx > phys)
        begin
            q_next = left;
        end
        else if (cmd.del && my_idx >= phys)
        begin
            q_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q     = q_reg;
    assign match = (q_reg == value);

endmodule

// ===== sv/ple_group.sv =====
// Registered reduction over one group of cells: first/last hit and selected entry.
module ple_group
    import ple_pkg::*;
(
    input  logic                             clk,
    input  logic [GRP_SIZE-1:0]              hits,
    input  logic [GRP_SIZE-1:0][DATA_W-1:0]  data,
    output grp_res_t                         res
);

    grp_res_t res_reg;
    grp_res_t res_next;

    always_comb
    begin
        res_next       = '0;
        res_next.hit   = |hits;
        for (int j = GRP_SIZE - 1; j >= 0; j--)
        begin
            if (hits[j])
            begin
                res_next.first = GRP_IW'(j);
            end
        end
        for (int j = 0; j < GRP_SIZE; j++)
        begin
            if (hits[j])
            begin
                res_next.last = GRP_IW'(j);
            end
            res_next.data = res_next.data | data[j];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== sv/positional_list_engine.sv =====
// Positional list engine: ordered list of signed entries in a row of shift cells.
//
// Requests enter on req when start is high and busy is low. Each request gives
// exactly one item on rsp, marked by done for one cycle; the receiver takes it
// then and cannot hold it off.
// Insert, delete, reverse, clear and unused codes finish in the cycle they are
// taken: the cells shift in parallel and done follows on the next cycle, with
// busy staying low, so such requests can be issued every cycle.
// Locate and read pass through registered steps: match/select bits are registered,
// reduced per group of cells, then combined; busy is high in the REDUCE and COMBINE
// states, and done comes with the registered result of the combine.
// Reverse only flips a direction flag; positions are mapped through it.
// Reset clears the length, the direction flag and the controller; entries hold
// whatever they had and are never read before being written.
// A new request may be taken in the cycle its predecessor's done is shown.
`include "assert_macros.svh"

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int NG = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NP = NG * GRP_SIZE;

    fsm_t               state_reg, state_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic               rev_reg, rev_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;
    logic [NP-1:0]      hit_reg, hit_next;
    logic [IW-1:0]      tgt_reg, tgt_next;
    logic               rd_op_reg, rd_op_next;
    logic [1:0]         stat_reg, stat_next;

    logic               accept;
    logic [AW-1:0]      pos_w, n_w, q_w, ins_phys, del_phys, cnt_w;
    logic               pos_zero, ins_bad, del_bad, full;
    logic [IW-1:0]      phys_idx;
    cell_cmd_t          cmd;

    logic [CAPACITY-1:0][DATA_W-1:0] cell_q, left_d, right_d;
    logic [CAPACITY-1:0]             cell_match;
    logic [NP-1:0][DATA_W-1:0]       sel_data;
    grp_res_t [NG-1:0]               grp;

    logic [AW-1:0]      k_first, k_last, found_w;
    logic               any_hit;
    logic [DATA_W-1:0]  rd_or;

    // request decode
    assign accept   = start && !busy;
    assign pos_w    = AW'(req.position);
    assign n_w      = AW'(fill_reg);
    assign q_w      = pos_w - AW'(1);
    assign pos_zero = (req.position == '0);
    assign ins_bad  = pos_zero || (pos_w > n_w + AW'(1));
    assign del_bad  = pos_zero || (pos_w > n_w);
    assign full     = (n_w >= AW'(CAPACITY));
    assign ins_phys = rev_reg ? (n_w - q_w) : q_w;
    assign del_phys = rev_reg ? (n_w - AW'(1) - q_w) : q_w;
    assign phys_idx = (req.func == FN_INSERT) ? ins_phys[IW-1:0] : del_phys[IW-1:0];

    assign cmd.ins = accept && (req.func == FN_INSERT) && !ins_bad && !full;
    assign cmd.del = accept && (req.func == FN_DELETE) && !del_bad;

    // row of cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign left_d[gi] = req.value;
            end
            else
            begin : g_mid_l
                assign left_d[gi] = cell_q[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d[gi] = cell_q[gi];
            end
            else
            begin : g_mid_r
                assign right_d[gi] = cell_q[gi+1];
            end

            ple_cell #(
                .IDX (gi),
                .IW  (IW)
            ) u_cell (
                .clk   (clk),
                .cmd   (cmd),
                .phys  (phys_idx),
                .value (req.value),
                .left  (left_d[gi]),
                .right (right_d[gi]),
                .q     (cell_q[gi]),
                .match (cell_match[gi])
            );
        end

        for (gi = 0; gi < NP; gi++)
        begin : g_sel
            if (gi < CAPACITY)
            begin : g_real
                assign sel_data[gi] = (tgt_reg == IW'(gi)) ? cell_q[gi] : '0;
            end
            else
            begin : g_pad
                assign sel_data[gi] = '0;
            end
        end

        for (gi = 0; gi < NG; gi++)
        begin : g_grp
            ple_group u_grp (
                .clk  (clk),
                .hits (hit_reg[gi*GRP_SIZE +: GRP_SIZE]),
                .data (sel_data[gi*GRP_SIZE +: GRP_SIZE]),
                .res  (grp[gi])
            );
        end
    endgenerate

    // locate hits, limited to the occupied cells
    always_comb
    begin
        hit_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_next[i] = cell_match[i] && (CW'(i) < fill_reg);
        end
    end

    // final combine over groups
    always_comb
    begin
        k_first = '0;
        k_last  = '0;
        any_hit = 1'b0;
        rd_or   = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp[g].hit)
            begin
                k_first = AW'(g * GRP_SIZE) + AW'(grp[g].first);
            end
        end
        for (int g = 0; g < NG; g++)
        begin
            if (grp[g].hit)
            begin
                k_last = AW'(g * GRP_SIZE) + AW'(grp[g].last);
            end
            any_hit = any_hit | grp[g].hit;
            rd_or   = rd_or | grp[g].data;
        end
        if (!any_hit || rd_op_reg)
        begin
            found_w = '0;
        end
        else if (rev_reg)
        begin
            found_w = n_w - k_last;
        end
        else
        begin
            found_w = k_first + AW'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept && (req.func == FN_LOCATE || req.func == FN_READ))
                begin
                    state_next = FSM_REDUCE;
                end
            end
            FSM_REDUCE:  state_next = FSM_COMBINE;
            FSM_COMBINE: state_next = FSM_IDLE;
            default:     state_next = FSM_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        busy       = 1'b1;
        fill_next  = fill_reg;
        rev_next   = rev_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        tgt_next   = tgt_reg;
        rd_op_next = rd_op_reg;
        stat_next  = stat_reg;
        cnt_w      = '0;
        case (state_reg)
            FSM_IDLE:
            begin
                busy = 1'b0;
                if (accept)
                begin
                    stat_next  = ST_OK;
                    rd_op_next = (req.func == FN_READ);
                    tgt_next   = del_phys[IW-1:0];
                    case (req.func)
                        FN_INSERT:
                        begin
                            if (ins_bad)
                            begin
                                stat_next = ST_BADPOS;
                            end
                            else if (full)
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        FN_DELETE:
                        begin
                            if (del_bad)
                            begin
                                stat_next = ST_BADPOS;
                            end
                            else
                            begin
                                fill_next = fill_reg - CW'(1);
                            end
                        end
                        FN_REVERSE: rev_next = !rev_reg;
                        FN_CLEAR:
                        begin
                            fill_next = '0;
                            rev_next  = 1'b0;
                        end
                        FN_READ:
                        begin
                            if (del_bad)
                            begin
                                stat_next = ST_BADPOS;
                                tgt_next  = '0;
                            end
                        end
                        default: ;
                    endcase
                    if (req.func != FN_LOCATE && req.func != FN_READ)
                    begin
                        cnt_w                   = AW'(fill_next);
                        done_next               = 1'b1;
                        rsp_next.status         = stat_next;
                        rsp_next.found_position = '0;
                        rsp_next.read_value     = '0;
                        rsp_next.count          = cnt_w[POS_W-1:0];
                    end
                end
            end
            FSM_REDUCE: ;
            FSM_COMBINE:
            begin
                cnt_w                   = n_w;
                done_next               = 1'b1;
                rsp_next.status         = stat_reg;
                rsp_next.found_position = found_w[POS_W-1:0];
                rsp_next.read_value     = (rd_op_reg && stat_reg == ST_OK) ? rd_or : '0;
                rsp_next.count          = cnt_w[POS_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            fill_reg  <= '0;
            rev_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            rev_reg   <= rev_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        hit_reg   <= hit_next;
        tgt_reg   <= tgt_next;
        rd_op_reg <= rd_op_next;
        stat_reg  <= stat_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CW'(CAPACITY), "length above capacity")
    `ASSERT_NEXT(a_long_op_busy, start && !busy && (req.func == FN_LOCATE || req.func == FN_READ), busy && !done, "locate/read did not hold busy")
    `ASSERT_NEXT(a_short_op_done, start && !busy && req.func != FN_LOCATE && req.func != FN_READ, done && !busy, "short item gave no result")
    `ASSERT_NOW(a_full_status, done && rsp.status == ST_FULL, fill_reg == CW'(CAPACITY), "full reported below capacity")

endmodule
